// ----- hdl/cubic_bezier_segment_sampler_assert.svh -----
// Assertion macros for the cubic Bezier segment sampler.
// Expects clk and rst_n in the scope of each use.
`ifndef CUBIC_BEZIER_SEGMENT_SAMPLER_ASSERT_SVH
`define CUBIC_BEZIER_SEGMENT_SAMPLER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BCS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define BCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BCS_ASSERT_IMPLY(label, ante, cons, msg)
`define BCS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/bcs_pkg.sv -----
// Shared types, constants and arithmetic helpers for the Bezier sampler.
// No dependencies.
`default_nettype none

package bcs_pkg;

  localparam int CW          = 32;   // coordinate width, signed Q16.16
  localparam int TW          = 16;   // parameter t width, unsigned Q0.16
  localparam int MAX_SAMPLES = 64;
  localparam int CNT_W       = 7;    // sample count register width
  localparam int IDX_W       = 6;    // sample index width
  localparam int PROD_W      = CW + TW + 2;
  localparam int LANE_LAT    = 6;    // register stages in one lane
  localparam int NUM_PTS     = 12;

  typedef logic signed [CW-1:0]     coord_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [TW-1:0]            frac_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // Sideband that travels with each issued sample.
  typedef struct packed {
    logic valid;
    idx_t idx;
    logic last;
  } smp_ctl_t;

  // (b - a) * t, full precision.
  function automatic prod_t lerp_prod(coord_t a, coord_t b, frac_t t);
    logic signed [CW:0] d;
    logic signed [TW:0] ts;
    d  = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
    ts = $signed({1'b0, t});
    return d * ts;
  endfunction

  // a + floor(m / 2^16); the result always lies between the two operands.
  function automatic coord_t lerp_sum(coord_t a, prod_t m);
    logic [CW+1:0] s;
    s = {{2{a[CW-1]}}, a} + m[PROD_W-1:TW];
    return coord_t'(s[CW-1:0]);
  endfunction

  // floor(2^16 / n) indexed by n - 1.
  function automatic logic [TW:0] step_quot(idx_t nm1);
    logic [TW:0] q;
    case (nm1)
      6'd0:  q = 17'd65536;  6'd1:  q = 17'd32768;  6'd2:  q = 17'd21845;
      6'd3:  q = 17'd16384;  6'd4:  q = 17'd13107;  6'd5:  q = 17'd10922;
      6'd6:  q = 17'd9362;   6'd7:  q = 17'd8192;   6'd8:  q = 17'd7281;
      6'd9:  q = 17'd6553;   6'd10: q = 17'd5957;   6'd11: q = 17'd5461;
      6'd12: q = 17'd5041;   6'd13: q = 17'd4681;   6'd14: q = 17'd4369;
      6'd15: q = 17'd4096;   6'd16: q = 17'd3855;   6'd17: q = 17'd3640;
      6'd18: q = 17'd3449;   6'd19: q = 17'd3276;   6'd20: q = 17'd3120;
      6'd21: q = 17'd2978;   6'd22: q = 17'd2849;   6'd23: q = 17'd2730;
      6'd24: q = 17'd2621;   6'd25: q = 17'd2520;   6'd26: q = 17'd2427;
      6'd27: q = 17'd2340;   6'd28: q = 17'd2259;   6'd29: q = 17'd2184;
      6'd30: q = 17'd2114;   6'd31: q = 17'd2048;   6'd32: q = 17'd1985;
      6'd33: q = 17'd1927;   6'd34: q = 17'd1872;   6'd35: q = 17'd1820;
      6'd36: q = 17'd1771;   6'd37: q = 17'd1724;   6'd38: q = 17'd1680;
      6'd39: q = 17'd1638;   6'd40: q = 17'd1598;   6'd41: q = 17'd1560;
      6'd42: q = 17'd1524;   6'd43: q = 17'd1489;   6'd44: q = 17'd1456;
      6'd45: q = 17'd1424;   6'd46: q = 17'd1394;   6'd47: q = 17'd1365;
      6'd48: q = 17'd1337;   6'd49: q = 17'd1310;   6'd50: q = 17'd1285;
      6'd51: q = 17'd1260;   6'd52: q = 17'd1236;   6'd53: q = 17'd1213;
      6'd54: q = 17'd1191;   6'd55: q = 17'd1170;   6'd56: q = 17'd1149;
      6'd57: q = 17'd1129;   6'd58: q = 17'd1110;   6'd59: q = 17'd1092;
      6'd60: q = 17'd1074;   6'd61: q = 17'd1057;   6'd62: q = 17'd1040;
      default: q = 17'd1024;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/bcs_in_if.sv -----
// Segment input channel: valid/ready plus the four control points.
// Depends on bcs_pkg.
`default_nettype none

interface bcs_in_if import bcs_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t p0_x, p0_y, p0_z;
  coord_t p1_x, p1_y, p1_z;
  coord_t p2_x, p2_y, p2_z;
  coord_t p3_x, p3_y, p3_z;

  modport source (
    output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
    output p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
    input  p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/bcs_out_if.sv -----
// Sample output channel: valid/ready plus point, index and last flag.
// Depends on bcs_pkg.
`default_nettype none

interface bcs_out_if import bcs_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t out_x, out_y, out_z;
  idx_t   sample_index;
  logic   last_sample;

  modport source (
    output valid, out_x, out_y, out_z, sample_index, last_sample,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, sample_index, last_sample,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/bcs_seq.sv -----
// Sample sequencer: steps n and t = floor(n * 2^16 / N) without a divider.
// Depends on bcs_pkg.
`default_nettype none

module bcs_seq import bcs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cnt_t     samples,
  input  wire logic     in_fire,
  input  wire logic     en,
  output logic          in_ready,
  output smp_ctl_t      iss,
  output frac_t         t_out
);

  localparam int QN_W = TW + CNT_W + 1;

  logic        busy_r, busy_nxt;
  idx_t        n_r, n_nxt;
  frac_t       t_r, t_nxt;
  idx_t        rem_r, rem_nxt;
  logic [TW:0] q_r, q_nxt;
  idx_t        r0_r, r0_nxt;
  idx_t        nlast_r, nlast_nxt;
  cnt_t        nsamp_r, nsamp_nxt;

  cnt_t            n_clamp;
  logic [TW:0]     q_new;
  logic [QN_W-1:0] qn;
  logic [QN_W-1:0] rem_full;
  cnt_t            rsum;
  logic            last;

  always_comb begin
    if (samples == '0) begin
      n_clamp = CNT_W'(1);
    end else if (samples > CNT_W'(MAX_SAMPLES)) begin
      n_clamp = CNT_W'(MAX_SAMPLES);
    end else begin
      n_clamp = samples;
    end
    q_new    = step_quot(IDX_W'(n_clamp - CNT_W'(1)));
    qn       = QN_W'(q_new) * QN_W'(n_clamp);
    rem_full = (QN_W'(1) << TW) - qn;
  end

  assign last     = (n_r == nlast_r);
  assign in_ready = !busy_r || (en && last);
  assign iss      = '{valid: busy_r, idx: n_r, last: last};
  assign t_out    = t_r;
  assign rsum     = {1'b0, rem_r} + {1'b0, r0_r};

  always_comb begin
    busy_nxt  = busy_r;
    n_nxt     = n_r;
    t_nxt     = t_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    r0_nxt    = r0_r;
    nlast_nxt = nlast_r;
    nsamp_nxt = nsamp_r;
    // advance one sample per enabled cycle; remainder keeps t exact
    if (busy_r && en) begin
      n_nxt = n_r + IDX_W'(1);
      if (rsum >= nsamp_r) begin
        rem_nxt = IDX_W'(rsum - nsamp_r);
        t_nxt   = TW'(t_r + q_r + 1'b1);
      end else begin
        rem_nxt = IDX_W'(rsum);
        t_nxt   = TW'(t_r + q_r);
      end
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (in_fire) begin
      busy_nxt  = 1'b1;
      n_nxt     = '0;
      t_nxt     = '0;
      rem_nxt   = '0;
      q_nxt     = q_new;
      r0_nxt    = rem_full[IDX_W-1:0];
      nlast_nxt = IDX_W'(n_clamp - CNT_W'(1));
      nsamp_nxt = n_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    n_r     <= n_nxt;
    t_r     <= t_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    r0_r    <= r0_nxt;
    nlast_r <= nlast_nxt;
    nsamp_r <= nsamp_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/bcs_lane.sv -----
// One coordinate lane: three pipelined de Casteljau levels, multiply then add.
// Depends on bcs_pkg.
`default_nettype none

module bcs_lane import bcs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   en,
  input  wire coord_t p0,
  input  wire coord_t p1,
  input  wire coord_t p2,
  input  wire coord_t p3,
  input  wire frac_t  t,
  output coord_t      pt
);

  prod_t  prod1_r [3];
  coord_t base1_r [3];
  coord_t lvl1_r  [3];
  prod_t  prod2_r [2];
  coord_t base2_r [2];
  coord_t lvl2_r  [2];
  prod_t  prod3_r;
  coord_t base3_r;
  coord_t pt_r;
  frac_t  t1_r, t2_r, t3_r, t4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // level one
      prod1_r[0] <= lerp_prod(p0, p1, t);
      prod1_r[1] <= lerp_prod(p1, p2, t);
      prod1_r[2] <= lerp_prod(p2, p3, t);
      base1_r[0] <= p0;
      base1_r[1] <= p1;
      base1_r[2] <= p2;
      t1_r       <= t;
      for (int i = 0; i < 3; i++) begin
        lvl1_r[i] <= lerp_sum(base1_r[i], prod1_r[i]);
      end
      t2_r <= t1_r;
      // level two
      for (int i = 0; i < 2; i++) begin
        prod2_r[i] <= lerp_prod(lvl1_r[i], lvl1_r[i+1], t2_r);
        base2_r[i] <= lvl1_r[i];
      end
      t3_r <= t2_r;
      for (int i = 0; i < 2; i++) begin
        lvl2_r[i] <= lerp_sum(base2_r[i], prod2_r[i]);
      end
      t4_r <= t3_r;
      // level three
      prod3_r <= lerp_prod(lvl2_r[0], lvl2_r[1], t4_r);
      base3_r <= lvl2_r[0];
      pt_r    <= lerp_sum(base3_r, prod3_r);
    end
  end

  assign pt = pt_r;

endmodule

`default_nettype wire

// ----- hdl/bcs_merge.sv -----
// Merge stage: aligns sideband with the lanes and holds the output word.
// Depends on bcs_pkg and bcs_out_if.
`default_nettype none

module bcs_merge import bcs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire smp_ctl_t iss,
  input  wire coord_t   x,
  input  wire coord_t   y,
  input  wire coord_t   z,
  output logic          en,
  bcs_out_if.source     out_smp
);

  smp_ctl_t ctl_r [LANE_LAT];
  logic     out_valid_r;
  coord_t   x_r, y_r, z_r;
  idx_t     idx_r;
  logic     last_r;

  // hold the whole pipeline while a word waits to be taken
  assign en = !out_valid_r || out_smp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        ctl_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl_r[0] <= iss;
      for (int i = 1; i < LANE_LAT; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
      out_valid_r <= ctl_r[LANE_LAT-1].valid;
    end
    if (en) begin
      x_r    <= x;
      y_r    <= y;
      z_r    <= z;
      idx_r  <= ctl_r[LANE_LAT-1].idx;
      last_r <= ctl_r[LANE_LAT-1].last;
    end
  end

  assign out_smp.valid        = out_valid_r;
  assign out_smp.out_x        = x_r;
  assign out_smp.out_y        = y_r;
  assign out_smp.out_z        = z_r;
  assign out_smp.sample_index = idx_r;
  assign out_smp.last_sample  = last_r;

endmodule

`default_nettype wire

// ----- hdl/cubic_bezier_segment_sampler.sv -----
// Cubic Bezier segment sampler. Each accepted word is one segment of four
// 3-D control points (signed Q16.16); the block answers with N sample words
// at t = floor(n * 2^16 / N), n = 0 .. N-1, where N is samples_per_segment
// (0 reads as 1, above 64 reads as 64, reset 16). The last word of a segment
// carries last_sample. Samples issue one per cycle while the output is not
// stalled, and the next segment is accepted in the cycle that issues the
// last sample of the current one. An accepted segment passes the sequencer
// register, six register stages in the x/y/z lanes (three multiply/add
// levels) and one output register. Output back-pressure holds the whole
// pipeline.
// samples_per_segment is latched when a segment is accepted; write it only
// while no segment is in flight.
// Depends on bcs_pkg, bcs_in_if, bcs_out_if, bcs_seq, bcs_lane, bcs_merge.
`default_nettype none

`include "cubic_bezier_segment_sampler_assert.svh"

module cubic_bezier_segment_sampler import bcs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  bcs_in_if.sink                in_seg,
  bcs_out_if.source             out_smp
);

  cnt_t     samples_r;
  coord_t   held_r [NUM_PTS];
  logic     in_fire;
  logic     en;
  smp_ctl_t iss;
  frac_t    t;
  coord_t   lane_pt [3];

  // samples_per_segment register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r <= CNT_W'(16);
    end else if (cfg_we) begin
      samples_r <= cfg_wdata;
    end
  end

  assign in_fire = in_seg.valid && in_seg.ready;

  // hold the control points of the segment being sampled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_r[0]  <= in_seg.p0_x;
      held_r[1]  <= in_seg.p0_y;
      held_r[2]  <= in_seg.p0_z;
      held_r[3]  <= in_seg.p1_x;
      held_r[4]  <= in_seg.p1_y;
      held_r[5]  <= in_seg.p1_z;
      held_r[6]  <= in_seg.p2_x;
      held_r[7]  <= in_seg.p2_y;
      held_r[8]  <= in_seg.p2_z;
      held_r[9]  <= in_seg.p3_x;
      held_r[10] <= in_seg.p3_y;
      held_r[11] <= in_seg.p3_z;
    end
  end

  bcs_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .samples  (samples_r),
    .in_fire  (in_fire),
    .en       (en),
    .in_ready (in_seg.ready),
    .iss      (iss),
    .t_out    (t)
  );

  // one lane per axis
  for (genvar a = 0; a < 3; a++) begin : g_lane
    bcs_lane u_lane (
      .clk (clk),
      .en  (en),
      .p0  (held_r[a]),
      .p1  (held_r[3+a]),
      .p2  (held_r[6+a]),
      .p3  (held_r[9+a]),
      .t   (t),
      .pt  (lane_pt[a])
    );
  end

  bcs_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .iss     (iss),
    .x       (lane_pt[0]),
    .y       (lane_pt[1]),
    .z       (lane_pt[2]),
    .en      (en),
    .out_smp (out_smp)
  );

  // sample zero always starts at t = 0
  `BCS_ASSERT_IMPLY(a_first_t_zero, iss.valid && iss.idx == '0, t == '0, "t not zero at n=0")
  // an accepted segment starts issuing at index zero next cycle
  `BCS_ASSERT_NEXT(a_accept_start, in_fire, iss.valid && iss.idx == '0, "segment did not start")
  // issuing the last sample frees the sequencer unless a new segment enters
  `BCS_ASSERT_NEXT(a_last_frees, iss.valid && iss.last && en && !in_fire, !iss.valid, "busy after last")

endmodule

`default_nettype wire
